@@ hw/rtl/gtq_pkg.sv @@
`timescale 1ns / 1ps

package gtq_pkg;

   localparam int DEF_ID_BITS   = 10;
   localparam int DEF_MAX_TEAMS = 16;
   localparam int DEF_CAPACITY  = 256;

   localparam int KIND_W   = 2;
   localparam int ELEM_W   = 10;
   localparam int TEAM_W   = 4;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ELEM_W-1:0] element;
      logic [TEAM_W-1:0] team;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ELEM_W-1:0]   dequeued_element;
   } rsp_type;

   // Strobes from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                asg_wr;
      logic                enq_look;
      logic                enq_commit;
      logic                deq_ring_rd;
      logic                deq_rec_rd;
      logic                deq_slot_rd;
      logic                deq_commit;
      logic                init_step;
      logic                clr_step;
      logic                set_res;
      logic [STATUS_W-1:0] res_code;
      logic                rsp_load;
   } cmd_type;

   // Conditions reported by the datapath.
   typedef struct packed {
      logic [KIND_W-1:0] req_kind;
      logic              unassigned;
      logic              full;
      logic              empty;
      logic              init_last;
      logic              clr_last;
      logic              out_free;
   } sts_type;

endpackage

@@ hw/rtl/gtq_ctrl.sv @@
`timescale 1ns / 1ps

module gtq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  gtq_pkg::sts_type sts,
   output gtq_pkg::cmd_type cmd
);
   import gtq_pkg::*;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_ASG  = 4'd2;
   localparam logic [3:0] S_ENQ1 = 4'd3;
   localparam logic [3:0] S_ENQ2 = 4'd4;
   localparam logic [3:0] S_DEQ1 = 4'd5;
   localparam logic [3:0] S_DEQ2 = 4'd6;
   localparam logic [3:0] S_DEQ3 = 4'd7;
   localparam logic [3:0] S_DEQ4 = 4'd8;
   localparam logic [3:0] S_CLR  = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (sts.req_kind)
                  KIND_ASSIGN:  state_in = S_ASG;
                  KIND_ENQUEUE: state_in = S_ENQ1;
                  KIND_DEQUEUE: state_in = S_DEQ1;
                  default:      state_in = S_CLR;
               endcase
            end
         end
         S_ASG: begin
            cmd.asg_wr   = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_ACCEPTED;
            state_in     = S_DONE;
         end
         S_ENQ1: begin
            if (sts.unassigned) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_UNASSIGNED;
               state_in     = S_DONE;
            end else if (sts.full) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_FULL;
               state_in     = S_DONE;
            end else begin
               cmd.enq_look = 1'b1;
               state_in     = S_ENQ2;
            end
         end
         S_ENQ2: begin
            cmd.enq_commit = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_code   = ST_ACCEPTED;
            state_in       = S_DONE;
         end
         S_DEQ1: begin
            if (sts.empty) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_EMPTY;
               state_in     = S_DONE;
            end else begin
               cmd.deq_ring_rd = 1'b1;
               state_in        = S_DEQ2;
            end
         end
         S_DEQ2: begin
            cmd.deq_rec_rd = 1'b1;
            state_in       = S_DEQ3;
         end
         S_DEQ3: begin
            cmd.deq_slot_rd = 1'b1;
            state_in        = S_DEQ4;
         end
         S_DEQ4: begin
            cmd.deq_commit = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_code   = ST_DEQUEUED;
            state_in       = S_DONE;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_ACCEPTED;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/gtq_datapath.sv @@
`timescale 1ns / 1ps

module gtq_datapath #(
   parameter int ID_BITS   = gtq_pkg::DEF_ID_BITS,
   parameter int MAX_TEAMS = gtq_pkg::DEF_MAX_TEAMS,
   parameter int CAPACITY  = gtq_pkg::DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  gtq_pkg::cmd_type cmd,
   output gtq_pkg::sts_type sts,
   input  gtq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gtq_pkg::rsp_type rsp_data
);
   import gtq_pkg::*;

   localparam int TABLE_N = 1 << ID_BITS;
   localparam int TW      = $clog2(MAX_TEAMS + 1);
   localparam int TIW     = $clog2(MAX_TEAMS);
   localparam int SW      = $clog2(CAPACITY);
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int OW      = $clog2(MAX_TEAMS + 1);
   localparam int SWEEP_N = (TABLE_N > MAX_TEAMS) ? TABLE_N : MAX_TEAMS;
   localparam int NW      = $clog2(SWEEP_N);

   typedef struct packed {
      logic          present;
      logic [SW-1:0] head;
      logic [SW-1:0] tail;
   } rec_type;

   // Memories.
   logic [TW-1:0]      tt_ff   [TABLE_N];
   rec_type            rec_ff  [MAX_TEAMS];
   logic [SW-1:0]      stk_ff  [CAPACITY];
   logic [ID_BITS-1:0] selem_ff[CAPACITY];
   logic [SW-1:0]      snext_ff[CAPACITY];
   logic [TIW-1:0]     ring_ff [MAX_TEAMS];

   // Registered read data.
   logic [TW-1:0]      tt_q_ff;
   rec_type            rec_q_ff;
   logic [SW-1:0]      stk_q_ff;
   logic [ID_BITS-1:0] elem_q_ff;
   logic [SW-1:0]      next_q_ff;
   logic [TIW-1:0]     ring_q_ff;

   // Item and control registers.
   logic [ID_BITS-1:0]  elem_ff;
   logic [TW-1:0]       code_ff;
   logic [TIW-1:0]      team_ff;
   logic [CW-1:0]       sp_ff, sp_in;
   logic [CW-1:0]       fresh_ff, fresh_in;
   logic [TIW-1:0]      ohead_ff, ohead_in;
   logic [TIW-1:0]      otail_ff, otail_in;
   logic [OW-1:0]       ocount_ff, ocount_in;
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic [STATUS_W-1:0] res_status_ff;
   logic [ELEM_W-1:0]   res_elem_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;

   logic [ID_BITS-1:0] req_idx;
   logic [CW-1:0]      sp_dec;
   logic [SW-1:0]      new_slot;
   logic               last_member;
   logic               sweep;
   logic               tt_we;
   logic [ID_BITS-1:0] tt_wa;
   logic [TW-1:0]      tt_wd;
   logic               rec_we;
   logic [TIW-1:0]     rec_wa;
   rec_type            rec_wd;
   logic [TIW-1:0]     rec_ra;

   assign req_idx     = ID_BITS'(req_data.element);
   assign sp_dec      = sp_ff - CW'(1);
   assign new_slot    = (sp_ff != '0) ? stk_q_ff : fresh_ff[SW-1:0];
   assign last_member = (rec_q_ff.head == rec_q_ff.tail);
   assign sweep       = cmd.init_step | cmd.clr_step;

   assign sts.req_kind   = req_data.kind;
   assign sts.unassigned = (tt_q_ff == TW'(MAX_TEAMS));
   assign sts.full       = (sp_ff == '0) && (fresh_ff == CW'(CAPACITY));
   assign sts.empty      = (ocount_ff == '0);
   assign sts.init_last  = (cnt_ff == NW'(SWEEP_N - 1));
   assign sts.clr_last   = (cnt_ff == NW'(MAX_TEAMS - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Team table write port: assign items and the clearing pass after reset.
   always_comb begin
      tt_we = 1'b0;
      tt_wa = elem_ff;
      tt_wd = code_ff;
      if (cmd.asg_wr) begin
         tt_we = 1'b1;
      end else if (cmd.init_step && (cnt_ff < TABLE_N)) begin
         tt_we = 1'b1;
         tt_wa = cnt_ff[ID_BITS-1:0];
         tt_wd = TW'(MAX_TEAMS);
      end
   end

   // Team record write port.
   always_comb begin
      rec_we = 1'b0;
      rec_wa = team_ff;
      rec_wd = rec_q_ff;
      rec_ra = cmd.enq_look ? tt_q_ff[TIW-1:0] : ring_q_ff;
      if (cmd.enq_commit) begin
         rec_we         = 1'b1;
         rec_wd.present = 1'b1;
         rec_wd.tail    = new_slot;
         if (!rec_q_ff.present) begin
            rec_wd.head = new_slot;
         end
      end else if (cmd.deq_commit) begin
         rec_we = 1'b1;
         if (last_member) begin
            rec_wd.present = 1'b0;
         end else begin
            rec_wd.head = next_q_ff;
         end
      end else if (sweep && (cnt_ff < MAX_TEAMS)) begin
         rec_we = 1'b1;
         rec_wa = cnt_ff[TIW-1:0];
         rec_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (tt_we) begin
         tt_ff[tt_wa] <= tt_wd;
      end
      if (cmd.load) begin
         tt_q_ff <= tt_ff[req_idx];
      end
      if (rec_we) begin
         rec_ff[rec_wa] <= rec_wd;
      end
      if (cmd.enq_look || cmd.deq_rec_rd) begin
         rec_q_ff <= rec_ff[rec_ra];
      end
      if (cmd.deq_commit) begin
         stk_ff[sp_ff[SW-1:0]] <= rec_q_ff.head;
      end
      if (cmd.enq_look) begin
         stk_q_ff <= stk_ff[sp_dec[SW-1:0]];
      end
      if (cmd.enq_commit) begin
         selem_ff[new_slot] <= elem_ff;
      end
      if (cmd.enq_commit && rec_q_ff.present) begin
         snext_ff[rec_q_ff.tail] <= new_slot;
      end
      if (cmd.deq_slot_rd) begin
         elem_q_ff <= selem_ff[rec_q_ff.head];
         next_q_ff <= snext_ff[rec_q_ff.head];
      end
      if (cmd.enq_commit && !rec_q_ff.present) begin
         ring_ff[otail_ff] <= team_ff;
      end
      if (cmd.deq_ring_rd) begin
         ring_q_ff <= ring_ff[ohead_ff];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         elem_ff <= req_idx;
         code_ff <= ({{(32 - TEAM_W){1'b0}}, req_data.team} < MAX_TEAMS) ?
                    TW'(req_data.team) : TW'(MAX_TEAMS);
      end
      if (cmd.enq_look) begin
         team_ff <= tt_q_ff[TIW-1:0];
      end else if (cmd.deq_rec_rd) begin
         team_ff <= ring_q_ff;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_code;
         res_elem_ff   <= (cmd.res_code == ST_DEQUEUED) ? ELEM_W'(elem_q_ff) : '0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status           <= res_status_ff;
         rsp_ff.dequeued_element <= res_elem_ff;
      end
   end

   always_comb begin
      sp_in        = sp_ff;
      fresh_in     = fresh_ff;
      ohead_in     = ohead_ff;
      otail_in     = otail_ff;
      ocount_in    = ocount_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.enq_commit) begin
         if (sp_ff != '0) begin
            sp_in = sp_dec;
         end else begin
            fresh_in = fresh_ff + CW'(1);
         end
         if (!rec_q_ff.present) begin
            otail_in  = (otail_ff == TIW'(MAX_TEAMS - 1)) ? '0 : otail_ff + TIW'(1);
            ocount_in = ocount_ff + OW'(1);
         end
      end
      if (cmd.deq_commit) begin
         sp_in = sp_ff + CW'(1);
         if (last_member) begin
            ohead_in  = (ohead_ff == TIW'(MAX_TEAMS - 1)) ? '0 : ohead_ff + TIW'(1);
            ocount_in = ocount_ff - OW'(1);
         end
      end
      if (cmd.clr_step) begin
         sp_in     = '0;
         fresh_in  = '0;
         ohead_in  = '0;
         otail_in  = '0;
         ocount_in = '0;
      end
      if (sweep) begin
         if ((cmd.init_step && sts.init_last) || (cmd.clr_step && sts.clr_last)) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + NW'(1);
         end
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         fresh_ff     <= '0;
         ohead_ff     <= '0;
         otail_ff     <= '0;
         ocount_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         fresh_ff     <= fresh_in;
         ohead_ff     <= ohead_in;
         otail_ff     <= otail_in;
         ocount_ff    <= ocount_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/grouped_team_queue.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Payload
// request   in         req_valid, req_stall (out)     req_data: kind, element, team
// response  out        rsp_valid, rsp_stall (in)      rsp_data: status, dequeued_element
//
// One item is worked on at a time. The steps of each item are set by the chain of
// registered reads through the team, slot and ring memories.
// After reset a clearing pass marks every element unassigned; req_stall stays
// high through it.
// A finished result waits in the response register while rsp_stall is high, and
// the next item is taken in the meantime.

module grouped_team_queue #(
   parameter int ID_BITS   = gtq_pkg::DEF_ID_BITS,
   parameter int MAX_TEAMS = gtq_pkg::DEF_MAX_TEAMS,
   parameter int CAPACITY  = gtq_pkg::DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gtq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gtq_pkg::rsp_type rsp_data
);
   import gtq_pkg::*;

   // The controller sequences each item; the datapath owns all storage.
   cmd_type cmd;
   sts_type sts;

   gtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gtq_datapath #(
      .ID_BITS   (ID_BITS),
      .MAX_TEAMS (MAX_TEAMS),
      .CAPACITY  (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The clearing pass keeps the request side stalled right after reset.
   a_init_stall : assert property (@(posedge clock) reset |=> req_stall)
      else $error("request accepted during the clearing pass");

   // Only one item is in flight: taking an item closes the request side.
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while one is in work");

   // Only a dequeue carries an element in its result.
   a_elem_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_DEQUEUED)) |-> (rsp_data.dequeued_element == '0))
      else $error("element reported on a result that is not a dequeue");

endmodule
